FILE: rtl/core/seq_pkg.sv
// ----------------------------------------------------------------------------
// seq_pkg
// Types, constants and helpers shared by the sorted event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package seq_pkg;

  localparam int LIST_DEPTH    = 64;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int TIME_W    = 48;
  localparam int IN_PAY_W  = 32;
  localparam int OUT_PAY_W = 32;
  localparam int OCC_W     = 7;

  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int SUM_W  = ADDR_W + 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]        ev_time;
    logic [PAYLOAD_WIDTH-1:0] ev_payload;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    status_t              status;
    logic [TIME_W-1:0]    ev_time;
    logic [OUT_PAY_W-1:0] ev_payload;
    logic [OCC_W-1:0]     occupancy;
    logic [OCC_W-1:0]     peak_occupancy;
  } res_t;

  typedef struct packed {
    logic load;
    res_t res;
  } out_req_t;

  // Physical slot of a list offset in the circular store.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(LIST_DEPTH)) begin
      sum = sum - SUM_W'(LIST_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/seq_chan_if.sv
// ----------------------------------------------------------------------------
// seq_in_if / seq_out_if
// Valid/ready channels for requests and results of the sorted event queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface seq_in_if
  import seq_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [TIME_W-1:0]   event_time;
  logic [IN_PAY_W-1:0] event_payload;

  modport source (output valid, req_type, event_time, event_payload, input ready);
  modport sink   (input valid, req_type, event_time, event_payload, output ready);
endinterface

interface seq_out_if
  import seq_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [TIME_W-1:0]    out_time;
  logic [OUT_PAY_W-1:0] out_payload;
  logic [OCC_W-1:0]     occupancy;
  logic [OCC_W-1:0]     peak_occupancy;

  modport source (output valid, status, out_time, out_payload, occupancy, peak_occupancy,
                  input ready);
  modport sink   (input valid, status, out_time, out_payload, occupancy, peak_occupancy,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sorted_event_queue.sv
// ----------------------------------------------------------------------------
// sorted_event_queue
// Future-event list kept sorted by 48-bit timestamp in one RAM.
// ----------------------------------------------------------------------------
// Events sit in a circular RAM of LIST_DEPTH slots, earliest at the head.
// A pop reads the head slot on acceptance and returns it from the pop state.
// An insert scans from the tail toward the head, moving each later event up
// one slot, one slot per cycle through the single RAM read and write port,
// and writes the new event behind the first earlier event or, in the place
// state, at the head. Equal times keep arrival order. Insert into an empty
// or full list and pop from an empty list finish in the idle state. A
// request is taken only while no other is in progress; a finished result
// waits in the output register without blocking the next request, but a
// result that finishes while that register is still occupied holds the
// controller, and with it the input, until the register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_event_queue
  import seq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  seq_in_if.sink    in_ch,
  seq_out_if.source out_ch
);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;
  out_req_t          out_req;
  logic              can_load;

  seq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(LIST_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  seq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_req  (out_req),
    .can_load (can_load)
  );

  seq_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (out_req),
    .can_load(can_load),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/core/seq_ram.sv
// ----------------------------------------------------------------------------
// seq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/seq_out_stage.sv
// ----------------------------------------------------------------------------
// seq_out_stage
// Result register; frees the control while a result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_out_stage
  import seq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire out_req_t  req,
  output logic           can_load,
  seq_out_if.source      out_ch
);

  logic valid_r;
  logic valid_nxt;
  res_t data_r;

  assign can_load  = !valid_r || out_ch.ready;
  assign valid_nxt = (req.load && can_load) || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load && can_load) begin
      data_r <= req.res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.status         = data_r.status;
  assign out_ch.out_time       = data_r.ev_time;
  assign out_ch.out_payload    = data_r.ev_payload;
  assign out_ch.occupancy      = data_r.occupancy;
  assign out_ch.peak_occupancy = data_r.peak_occupancy;

endmodule

`default_nettype wire

FILE: rtl/core/seq_ctrl.sv
// ----------------------------------------------------------------------------
// seq_ctrl
// Sequencer for the circular sorted store: tail-to-head insert scan with
// one shift per cycle, head pop, counts and result build.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_ctrl
  import seq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  seq_in_if.sink                 in_ch,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [SLOT_W-1:0]      ram_wdata,
  output logic                   ram_re,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire logic [SLOT_W-1:0] ram_rdata,
  output out_req_t               out_req,
  input  wire logic              can_load
);

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        head_r, head_nxt;
  logic [ADDR_W-1:0]        cur_r, cur_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         peak_r, peak_nxt;
  logic [TIME_W-1:0]        t_r, t_nxt;
  logic [PAYLOAD_WIDTH-1:0] p_r, p_nxt;
  res_t                     hold_r, hold_nxt;

  slot_t            rd_slot;
  slot_t            new_slot;
  slot_t            in_slot;
  res_t             res_fin;
  logic             acc;
  logic             is_pop;
  logic             full;
  logic             empty;
  logic             gt;
  logic             fin;
  logic [CNT_W-1:0] cnt_inc;

  assign rd_slot  = slot_t'(ram_rdata);
  assign new_slot = '{ev_time: t_r, ev_payload: p_r};
  assign in_slot  = '{ev_time: in_ch.event_time,
                      ev_payload: PAYLOAD_WIDTH'(in_ch.event_payload)};

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc     = in_ch.valid && in_ch.ready;
  assign is_pop  = (in_ch.req_type == REQ_POP);
  assign full    = (cnt_r == CNT_W'(LIST_DEPTH));
  assign empty   = (cnt_r == '0);
  assign gt      = (rd_slot.ev_time > t_r);
  assign cnt_inc = cnt_r + 1'b1;

  assign fin = ((state_r == S_IDLE) && acc &&
                (is_pop ? empty : (full || empty))) ||
               ((state_r == S_SCAN) && !gt) ||
               (state_r == S_PLACE) ||
               (state_r == S_POP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && !fin) begin
          state_nxt = is_pop ? S_POP : S_SCAN;
        end else if (fin) begin
          state_nxt = can_load ? S_IDLE : S_HOLD;
        end
      end
      S_SCAN: begin
        if (gt) begin
          state_nxt = (cur_r == '0) ? S_PLACE : S_SCAN;
        end else begin
          state_nxt = can_load ? S_IDLE : S_HOLD;
        end
      end
      S_PLACE, S_POP: begin
        state_nxt = can_load ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    head_nxt  = head_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    peak_nxt  = peak_r;
    t_nxt     = t_r;
    p_nxt     = p_r;
    res_fin   = '0;
    res_fin.status = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          t_nxt = in_slot.ev_time;
          p_nxt = in_slot.ev_payload;
          if (is_pop) begin
            if (empty) begin
              res_fin.status = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
            end
          end else if (full) begin
            res_fin.status = ST_FULL;
          end else if (empty) begin
            ram_we    = 1'b1;
            ram_waddr = head_r;
            ram_wdata = in_slot;
            cnt_nxt   = cnt_inc;
          end else begin
            ram_re    = 1'b1;
            cur_nxt   = ADDR_W'(cnt_r - 1'b1);
            ram_raddr = phys_addr(head_r, cur_nxt);
          end
        end
      end
      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = phys_addr(head_r, ADDR_W'(cur_r + 1'b1));
        if (gt) begin
          ram_wdata = rd_slot;
          if (cur_r != '0) begin
            ram_re    = 1'b1;
            cur_nxt   = cur_r - 1'b1;
            ram_raddr = phys_addr(head_r, cur_nxt);
          end
        end else begin
          ram_wdata = new_slot;
          cnt_nxt   = cnt_inc;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = head_r;
        ram_wdata = new_slot;
        cnt_nxt   = cnt_inc;
      end
      S_POP: begin
        res_fin.ev_time    = rd_slot.ev_time;
        res_fin.ev_payload = OUT_PAY_W'(rd_slot.ev_payload);
        head_nxt = phys_addr(head_r, ADDR_W'(1));
        cnt_nxt  = cnt_r - 1'b1;
      end
      S_HOLD: begin
      end
      default: begin
      end
    endcase

    if (cnt_nxt > peak_r) begin
      peak_nxt = cnt_nxt;
    end
    res_fin.occupancy      = OCC_W'(cnt_nxt);
    res_fin.peak_occupancy = OCC_W'(peak_nxt);

    hold_nxt = (fin && !can_load) ? res_fin : hold_r;

    out_req.load = fin || (state_r == S_HOLD);
    out_req.res  = (state_r == S_HOLD) ? hold_r : res_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cur_r   <= '0;
      cnt_r   <= '0;
      peak_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    p_r    <= p_nxt;
    hold_r <= hold_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LIST_DEPTH))
    else $error("event count beyond list depth");

  a_peak_ge_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= cnt_r)
    else $error("peak below current count");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write to same slot in one cycle");

  a_pop_path: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_pop && !empty) |=> (state_r == S_POP))
    else $error("pop of non-empty list did not enter pop state");

  a_scan_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> $past(ram_re))
    else $error("scan step without a pending read");

endmodule

`default_nettype wire
